>>> rtl/core/mhpq_pkg.sv
// Package: shared types and constants for the max-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;
   localparam int CAPACITY = 255;
   localparam int TAG_BITS = 16;
   localparam int PRIO_W = 32;
   localparam int TAG_W = 16;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W = CNT_W;
   localparam int FIFO_DEPTH = 2;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // request handed from the front part to the heap engine
   typedef struct packed {
      op_type op;
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;
endpackage

>>> rtl/core/mhpq_front.sv
// Front part: accepts requests and buffers them in a short command queue.
`timescale 1ns / 1ps
module mhpq_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_req_type,
   input  logic signed [mhpq_pkg::PRIO_W-1:0] req_in_priority,
   input  logic [mhpq_pkg::TAG_W-1:0] req_in_tag,
   output logic cmd_valid,
   input  logic cmd_take,
   output mhpq_pkg::cmd_type cmd
);
   import mhpq_pkg::*;

   cmd_type slot_ff [FIFO_DEPTH];
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;
   cmd_type new_cmd;

   assign req_full = (cnt_ff == 2'(FIFO_DEPTH));
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = slot_ff[rd_ptr_ff];
   assign do_push = req_push && !req_full;
   assign do_pop = cmd_take && cmd_valid;

   // classify the request; tag masked to its stored width
   always_comb begin
      new_cmd.op = op_type'(req_req_type);
      new_cmd.prio = req_in_priority;
      new_cmd.tag = req_in_tag[TAG_BITS-1:0];
   end

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= new_cmd;
   end
endmodule

>>> rtl/core/mhpq_engine.sv
// Back part: heap store in a memory and the sift-up / sift-down sequencer.
`timescale 1ns / 1ps
module mhpq_engine (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_take,
   input  mhpq_pkg::cmd_type cmd,
   input  logic rsp_pop,
   output logic rsp_empty,
   output logic [1:0] rsp_status,
   output logic signed [mhpq_pkg::PRIO_W-1:0] rsp_out_priority,
   output logic [mhpq_pkg::TAG_W-1:0] rsp_out_tag,
   output logic [7:0] rsp_occupancy
);
   import mhpq_pkg::*;

   localparam int ENT_W = PRIO_W + TAG_BITS;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_UPRD  = 9'b000000010,
      S_UPCMP = 9'b000000100,
      S_RMRD  = 9'b000001000,
      S_RMTOP = 9'b000010000,
      S_DNRDL = 9'b000100000,
      S_DNRDR = 9'b001000000,
      S_DNCMP = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   logic [ENT_W-1:0] mem [CAPACITY+1];
   logic [ENT_W-1:0] rdata_ff;
   logic [ADDR_W-1:0] raddr;
   logic re, we;
   logic [ADDR_W-1:0] waddr;
   logic [ENT_W-1:0] wdata;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W:0] kid_ff, kid_in;
   logic [ENT_W-1:0] item_ff, item_in;
   logic [ENT_W-1:0] left_ff, left_in;
   logic [ENT_W-1:0] top_ff, top_in;
   logic full_ff, full_in;
   logic [1:0] st_ff, st_in;
   logic signed [PRIO_W-1:0] oprio_ff, oprio_in;
   logic [TAG_W-1:0] otag_ff, otag_in;
   logic [7:0] occ_ff, occ_in;

   logic signed [PRIO_W-1:0] item_p, rd_p, left_p;
   logic [ENT_W-1:0] big;
   logic signed [PRIO_W-1:0] big_p;
   logic [ADDR_W:0] big_idx;

   assign item_p = item_ff[ENT_W-1 -: PRIO_W];
   assign rd_p = rdata_ff[ENT_W-1 -: PRIO_W];
   assign left_p = left_ff[ENT_W-1 -: PRIO_W];
   assign rsp_empty = !full_ff;
   assign rsp_status = st_ff;
   assign rsp_out_priority = oprio_ff;
   assign rsp_out_tag = otag_ff;
   assign rsp_occupancy = occ_ff;

   // larger child: right only when strictly greater
   always_comb begin
      if (kid_ff < (ADDR_W+1)'(count_ff) && left_p < rd_p) begin
         big = rdata_ff;
         big_idx = kid_ff + 1'b1;
      end else begin
         big = left_ff;
         big_idx = kid_ff;
      end
      big_p = big[ENT_W-1 -: PRIO_W];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      kid_in = kid_ff;
      item_in = item_ff;
      left_in = left_ff;
      top_in = top_ff;
      full_in = full_ff;
      st_in = st_ff;
      oprio_in = oprio_ff;
      otag_in = otag_ff;
      occ_in = occ_ff;
      re = 1'b0;
      raddr = '0;
      we = 1'b0;
      waddr = '0;
      wdata = item_ff;
      cmd_take = 1'b0;
      if (full_ff && rsp_pop) full_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && (!full_ff || rsp_pop)) begin
               cmd_take = 1'b1;
               st_in = ST_OK;
               oprio_in = '0;
               otag_in = '0;
               item_in = {cmd.prio, cmd.tag};
               if (cmd.op == OP_INSERT) begin
                  if (int'(count_ff) >= CAPACITY) begin
                     st_in = ST_OVERFLOW;
                     state_in = S_DONE;
                  end else begin
                     count_in = count_ff + 1'b1;
                     pos_in = count_ff + 1'b1;
                     state_in = S_UPRD;
                  end
               end else if (count_ff == '0) begin
                  st_in = ST_UNDERFLOW;
                  state_in = S_DONE;
               end else begin
                  re = 1'b1;
                  raddr = ADDR_W'(1);
                  state_in = S_RMRD;
               end
            end
         end
         S_UPRD: begin
            if (pos_ff > ADDR_W'(1)) begin
               re = 1'b1;
               raddr = pos_ff >> 1;
               state_in = S_UPCMP;
            end else begin
               we = 1'b1;
               waddr = pos_ff;
               state_in = S_DONE;
            end
         end
         S_UPCMP: begin
            if (rd_p < item_p) begin
               we = 1'b1;
               waddr = pos_ff;
               wdata = rdata_ff;
               pos_in = pos_ff >> 1;
               state_in = S_UPRD;
            end else begin
               we = 1'b1;
               waddr = pos_ff;
               state_in = S_DONE;
            end
         end
         S_RMRD: begin
            // root is in rdata; fetch last item
            top_in = rdata_ff;
            re = 1'b1;
            raddr = count_ff;
            state_in = S_RMTOP;
         end
         S_RMTOP: begin
            item_in = rdata_ff;
            count_in = count_ff - 1'b1;
            oprio_in = top_ff[ENT_W-1 -: PRIO_W];
            otag_in = TAG_W'(top_ff[TAG_BITS-1:0]);
            pos_in = ADDR_W'(1);
            kid_in = (ADDR_W+1)'(2);
            state_in = S_DNRDL;
         end
         S_DNRDL: begin
            if (kid_ff <= (ADDR_W+1)'(count_ff)) begin
               re = 1'b1;
               raddr = kid_ff[ADDR_W-1:0];
               state_in = S_DNRDR;
            end else begin
               we = 1'b1;
               waddr = pos_ff;
               state_in = S_DONE;
            end
         end
         S_DNRDR: begin
            left_in = rdata_ff;
            re = 1'b1;
            raddr = (kid_ff < (ADDR_W+1)'(count_ff)) ? ADDR_W'(kid_ff + 1'b1)
                                                       : kid_ff[ADDR_W-1:0];
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (item_p >= big_p) begin
               we = 1'b1;
               waddr = pos_ff;
               state_in = S_DONE;
            end else begin
               we = 1'b1;
               waddr = pos_ff;
               wdata = big;
               pos_in = big_idx[ADDR_W-1:0];
               kid_in = big_idx << 1;
               state_in = S_DNRDL;
            end
         end
         S_DONE: begin
            occ_in = 8'(count_ff);
            full_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      kid_ff <= kid_in;
      item_ff <= item_in;
      left_ff <= left_in;
      top_ff <= top_in;
      st_ff <= st_in;
      oprio_ff <= oprio_in;
      otag_ff <= otag_in;
      occ_ff <= occ_in;
   end

   // heap store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end
endmodule

>>> rtl/core/max_heap_priority_queue.sv
// Top level: binary max-heap priority queue.
//
// Requests enter through a queue-like port: req_push with req_full as back
// pressure; req_req_type selects insert or remove of the maximum item.
// Every request yields exactly one response, shown on the rsp_ ports while
// rsp_empty is low and taken by rsp_pop. Status reports ok, underflow on a
// remove from an empty heap, or overflow on an insert into a full heap.
// A two-entry command queue holds requests while the heap engine works.
// An insert sifts the new item up from the end of the heap level by level; a
// remove takes the root as result, moves the last item to the root and sifts
// it down level by level. Underflow and overflow answer without a heap access.
// The sequencer makes at most one heap memory access a cycle.
// The result register holds one response; if it is not popped, the engine
// waits with its next command, then the command queue fills and req_full
// rises. Reset empties the heap and both queues; memory contents are kept
// but unused.
`timescale 1ns / 1ps
module max_heap_priority_queue (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_req_type,
   input  logic signed [31:0] req_in_priority,
   input  logic [15:0] req_in_tag,
   input  logic rsp_pop,
   output logic rsp_empty,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_out_priority,
   output logic [15:0] rsp_out_tag,
   output logic [7:0] rsp_occupancy
);
   import mhpq_pkg::*;

   cmd_type cmd;
   logic cmd_valid, cmd_take;

   mhpq_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_req_type(req_req_type), .req_in_priority(req_in_priority),
      .req_in_tag(req_in_tag),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
   );

   mhpq_engine u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_status(rsp_status),
      .rsp_out_priority(rsp_out_priority), .rsp_out_tag(rsp_out_tag),
      .rsp_occupancy(rsp_occupancy)
   );
endmodule
